[rtl/psn_pkg.sv]
// ----------------------------------------------------------------------------
// psn_pkg: shared constants and types for the path to short name block
// Name geometry, character codes and the queued name entry.
// ----------------------------------------------------------------------------
package psn_pkg;

    localparam int NameLen    = 11;
    localparam int BaseLen    = 8;
    localparam int QueueDepth = 2;

    localparam logic [7:0] CharSpace  = 8'h20;
    localparam logic [7:0] CharSlash  = 8'h2f;
    localparam logic [7:0] CharDot    = 8'h2e;
    localparam logic [7:0] CharLowA   = 8'h61;
    localparam logic [7:0] CharLowZ   = 8'h7a;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam logic [3:0] FillBase = 4'(BaseLen);
    localparam logic [3:0] FillName = 4'(NameLen);
    localparam logic [3:0] LastIdx  = 4'(NameLen - 1);

    typedef logic [NameLen-1:0][7:0] name_bytes_t;

    typedef struct packed {
        name_bytes_t bytes;
        logic        final_comp;
    } name_entry_t;

endpackage

[rtl/psn_front.sv]
// ----------------------------------------------------------------------------
// psn_front: path character parser
// Classifies each character, builds the 11-byte name and hands finished
// names to the queue.
// ----------------------------------------------------------------------------
module psn_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           path_char,
    output logic                 push,
    output psn_pkg::name_entry_t push_entry
);

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_SLASH = 2'd1;
    localparam logic [1:0] PH_COMP  = 2'd2;

    psn_pkg::name_bytes_t name_buf_reg, name_buf_next;
    logic [3:0]           fill_reg, fill_next;
    logic                 ext_reg, ext_next;
    logic [1:0]           phase_reg, phase_next;

    logic       in_comp;
    logic       emit;
    logic       emit_final;
    logic [3:0] limit;
    logic [7:0] up_char;

    always_comb
    begin
        limit   = ext_reg ? psn_pkg::FillName : psn_pkg::FillBase;
        up_char = path_char;
        if (path_char >= psn_pkg::CharLowA && path_char <= psn_pkg::CharLowZ)
        begin
            up_char = path_char - psn_pkg::CaseOffset;
        end
    end

    always_comb
    begin
        name_buf_next = name_buf_reg;
        fill_next     = fill_reg;
        ext_next      = ext_reg;
        phase_next    = phase_reg;
        in_comp       = 1'b0;
        emit          = 1'b0;
        emit_final    = 1'b0;

        case (phase_reg)
            PH_SKIP:
            begin
                if (path_char == psn_pkg::CharSlash)
                begin
                    phase_next = PH_SLASH;
                end
                else if (path_char > psn_pkg::CharSpace)
                begin
                    in_comp = 1'b1;
                end
            end
            PH_SLASH:
            begin
                if (path_char < psn_pkg::CharSpace)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    in_comp = 1'b1;
                end
            end
            default:
            begin
                in_comp = 1'b1;
            end
        endcase

        if (in_comp)
        begin
            phase_next = PH_COMP;
            if (path_char <= psn_pkg::CharSpace || path_char == psn_pkg::CharSlash)
            begin
                emit       = 1'b1;
                emit_final = (path_char <= psn_pkg::CharSpace);
            end
            else if (path_char == psn_pkg::CharDot || fill_reg >= limit)
            begin
                if (ext_reg || path_char != psn_pkg::CharDot)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    fill_next = psn_pkg::FillBase;
                    ext_next  = 1'b1;
                end
            end
            else
            begin
                // fill is below the limit here, so always inside the name
                name_buf_next[fill_reg] = up_char;
                fill_next               = fill_reg + 4'd1;
            end
        end

        if (emit)
        begin
            name_buf_next = {psn_pkg::NameLen{psn_pkg::CharSpace}};
            fill_next     = 4'd0;
            ext_next      = 1'b0;
            phase_next    = emit_final ? PH_SKIP : PH_COMP;
        end
    end

    assign push                  = accept & emit;
    assign push_entry.bytes      = name_buf_reg;
    assign push_entry.final_comp = emit_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_buf_reg <= {psn_pkg::NameLen{psn_pkg::CharSpace}};
            fill_reg     <= 4'd0;
            ext_reg      <= 1'b0;
            phase_reg    <= PH_SKIP;
        end
        else if (accept)
        begin
            name_buf_reg <= name_buf_next;
            fill_reg     <= fill_next;
            ext_reg      <= ext_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

[rtl/psn_queue.sv]
// ----------------------------------------------------------------------------
// psn_queue: finished name queue
// Two-entry queue of complete names between the parser and the serialiser.
// ----------------------------------------------------------------------------
module psn_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psn_pkg::name_entry_t push_entry,
    input  logic                 pop,
    output psn_pkg::name_entry_t head,
    output logic                 full,
    output logic                 empty
);

    localparam int PtrW = $clog2(psn_pkg::QueueDepth);
    localparam int CntW = $clog2(psn_pkg::QueueDepth + 1);

    psn_pkg::name_entry_t entry_reg [psn_pkg::QueueDepth];
    logic [PtrW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]      count_reg, count_next;

    assign full  = (count_reg == CntW'(psn_pkg::QueueDepth));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/psn_back.sv]
// ----------------------------------------------------------------------------
// psn_back: name serialiser
// Sends the head name of the queue one byte per item, index 0 to 10.
// ----------------------------------------------------------------------------
module psn_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  psn_pkg::name_entry_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           name_byte,
    output logic [3:0]           byte_index,
    output logic                 final_component,
    output logic                 last
);

    logic [3:0] idx_reg;
    logic       take;

    assign out_valid       = ~empty;
    assign take            = out_valid & ~out_stall;
    assign name_byte       = head.bytes[idx_reg];
    assign byte_index      = idx_reg;
    assign final_component = head.final_comp;
    assign last            = (idx_reg == psn_pkg::LastIdx);
    assign pop             = take & last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd0;
        end
        else if (take)
        begin
            idx_reg <= last ? 4'd0 : idx_reg + 4'd1;
        end
    end

endmodule

[rtl/path_to_short_name_top.sv]
// ----------------------------------------------------------------------------
// path_to_short_name_top: path string to 8.3 short name converter
// Parser front end, two-name queue and byte serialiser.
// ----------------------------------------------------------------------------
// Input: one path character per cycle while the queue has room.
// A name is queued with its ending character and sent after earlier names.
// Output: 11 items/name, one per cycle unless stalled; serialiser sets rate.
// Input stalls only while two finished names wait in the queue.
// Reset (rst_n low, async) clears all control state and fills the name buffer
// with spaces; no clearing pass is needed afterwards.
module path_to_short_name_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] path_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] name_byte,
    output logic [3:0] byte_index,
    output logic       final_component,
    output logic       last
);

    psn_pkg::name_entry_t push_entry;
    psn_pkg::name_entry_t head;
    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    psn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .path_char  (path_char),
        .push       (push),
        .push_entry (push_entry)
    );

    psn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    psn_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .name_byte       (name_byte),
        .byte_index      (byte_index),
        .final_component (final_component),
        .last            (last)
    );

endmodule

[rtl/psn_chk.sv]
// ----------------------------------------------------------------------------
// psn_chk: port-level checks for the short name converter
// Watches the output item sequence of each name.
// ----------------------------------------------------------------------------
module psn_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] name_byte,
    input logic [3:0] byte_index,
    input logic       final_component,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(name_byte)
            && $stable(byte_index) && $stable(final_component))
        else $error("output item changed while stalled");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_index <= 4'd10) && (last == (byte_index == 4'd10)))
        else $error("byte index or last flag out of step");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid
            && byte_index == $past(byte_index) + 4'd1
            && final_component == $past(final_component))
        else $error("name run broken");

    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid || byte_index == 4'd0)
        else $error("next name does not start at byte 0");

endmodule

bind path_to_short_name_top psn_chk u_psn_chk
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .name_byte       (name_byte),
    .byte_index      (byte_index),
    .final_component (final_component),
    .last            (last)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: path to short name converter testbench
// Feeds path characters, first from a fixed table then as random paths and
// noise, and checks every name byte against a local 8.3 name predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WatchdogLimit = 2000;
    localparam int SqueezeCycles = 100;
    localparam int DrainCycles   = 20;
    localparam int RandomChars   = 150;
    localparam int SqueezeAfter  = 60;

    typedef enum logic [1:0] {PhSkip, PhSlash, PhComp} path_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] idx;
        logic       final_comp;
        logic       is_last;
    } name_byte_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] results;
    } path_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] path_char = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] name_byte;
    logic [3:0] byte_index;
    logic       final_component;
    logic       last;

    name_byte_t expected_name_bytes [$];
    int         mismatches = 0;
    int         random_chars = 0;
    int         idle_cycles = 0;
    int         tx_calm = 0;
    int         rx_calm = 0;
    bit         squeeze_req = 1'b0;
    bit         squeeze_done = 1'b0;

    // shadow of the converter state
    logic [7:0]  shadow_name [psn_pkg::NameLen];
    logic [3:0]  shadow_fill;
    logic        shadow_ext;
    path_phase_t shadow_phase;

    // empty paths, slash handling, case folding, dots, overflow, path end
    path_row_t directed_rows [26] = '{
        '{8'h00, 4'd0},                              // empty path
        '{psn_pkg::CharSpace, 4'd0},                 // leading space dropped
        '{psn_pkg::CharSlash, 4'd0},
        '{8'h1f, 4'd0},                              // control char after slash
        '{psn_pkg::CharSlash, 4'd0},
        '{psn_pkg::CharSlash, psn_pkg::FillName},    // second slash: empty name
        '{"a", 4'd0},
        '{"z", 4'd0},
        '{psn_pkg::CharDot, 4'd0},
        '{8'hff, 4'd0},                              // high byte kept as is
        '{psn_pkg::CharDot, psn_pkg::FillName},      // second dot ends the name
        '{"1", 4'd0},
        '{"2", 4'd0},
        '{"3", 4'd0},
        '{"4", 4'd0},
        '{"5", 4'd0},
        '{"6", 4'd0},
        '{"7", 4'd0},
        '{"8", 4'd0},
        '{"9", psn_pkg::FillName},                   // base overflow
        '{psn_pkg::CharDot, 4'd0},                   // dot with empty base
        '{"x", 4'd0},
        '{"y", 4'd0},
        '{"w", 4'd0},
        '{"q", psn_pkg::FillName},                   // extension overflow
        '{psn_pkg::CharSpace, psn_pkg::FillName}     // final component, empty
    };

    path_to_short_name_top dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .path_char       (path_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .name_byte       (name_byte),
        .byte_index      (byte_index),
        .final_component (final_component),
        .last            (last)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void clear_shadow_name();
        for (int k = 0; k < psn_pkg::NameLen; k++)
            shadow_name[k] = psn_pkg::CharSpace;
        shadow_fill = 4'd0;
        shadow_ext  = 1'b0;
    endfunction

    function automatic int emit_short_name(input logic final_comp);
        name_byte_t nb;
        for (int k = 0; k < psn_pkg::NameLen; k++)
        begin
            nb.ch         = shadow_name[k];
            nb.idx        = 4'(k);
            nb.final_comp = final_comp;
            nb.is_last    = (k == psn_pkg::NameLen - 1);
            expected_name_bytes.push_back(nb);
        end
        clear_shadow_name();
        shadow_phase = final_comp ? PhSkip : PhComp;
        return psn_pkg::NameLen;
    endfunction

    function automatic int take_component_char(input logic [7:0] c);
        logic [3:0] limit;
        limit = shadow_ext ? psn_pkg::FillName : psn_pkg::FillBase;
        shadow_phase = PhComp;
        if (c <= psn_pkg::CharSpace || c == psn_pkg::CharSlash)
            return emit_short_name(c <= psn_pkg::CharSpace);
        if (c == psn_pkg::CharDot || shadow_fill >= limit)
        begin
            if (shadow_ext || c != psn_pkg::CharDot)
                return emit_short_name(1'b0);
            shadow_fill = psn_pkg::FillBase;
            shadow_ext  = 1'b1;
            return 0;
        end
        if (c >= psn_pkg::CharLowA && c <= psn_pkg::CharLowZ)
            c = c - psn_pkg::CaseOffset;
        shadow_name[shadow_fill] = c;
        shadow_fill = shadow_fill + 4'd1;
        return 0;
    endfunction

    // returns the number of name bytes the char releases
    function automatic int shorten_char(input logic [7:0] c);
        case (shadow_phase)
            PhSkip:
            begin
                if (c <= psn_pkg::CharSpace)
                    return 0;
                if (c == psn_pkg::CharSlash)
                begin
                    shadow_phase = PhSlash;
                    return 0;
                end
                return take_component_char(c);
            end
            PhSlash:
            begin
                if (c < psn_pkg::CharSpace)
                begin
                    shadow_phase = PhSkip;
                    return 0;
                end
                return take_component_char(c);
            end
            default:
                return take_component_char(c);
        endcase
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm run
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] random_name_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = 8'($urandom_range(psn_pkg::CharLowA, psn_pkg::CharLowZ));
            4, 5:       c = 8'($urandom_range(8'h41, 8'h5a));
            6:          c = 8'($urandom_range(8'h30, 8'h39));
            7:          c = 8'($urandom_range(8'h80, 8'hff));
            default:
            begin
                do
                    c = 8'($urandom_range(8'h21, 8'h7e));
                while (c == psn_pkg::CharSlash || c == psn_pkg::CharDot);
            end
        endcase
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, output int produced);
        int  gap;
        bit  ignored;
        gap = (squeeze_req && !squeeze_done) ? 0 : pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        path_char <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ignored  = (shadow_phase == PhSkip && c <= psn_pkg::CharSpace);
        produced = shorten_char(c);
        if (!ignored)
            random_chars++;
    endtask

    task automatic send_random_path();
        logic [7:0] path [$];
        int         n_comp;
        int         base_len;
        int         ext_len;
        int         produced;
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 6))
                path.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                path.push_back(psn_pkg::CharSpace);
            if ($urandom_range(0, 9) < 7)
                path.push_back(psn_pkg::CharSlash);
            n_comp = $urandom_range(1, 3);
            for (int k = 0; k < n_comp; k++)
            begin
                if (k > 0)
                    path.push_back(psn_pkg::CharSlash);
                base_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10)
                                                       : $urandom_range(1, 8);
                repeat (base_len)
                    path.push_back(random_name_char());
                if ($urandom_range(0, 9) < 6)
                begin
                    path.push_back(psn_pkg::CharDot);
                    ext_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5)
                                                          : $urandom_range(0, 3);
                    repeat (ext_len)
                        path.push_back(random_name_char());
                    if ($urandom_range(0, 19) == 0)
                        path.push_back(psn_pkg::CharDot);
                end
            end
            path.push_back(8'($urandom_range(0, 32)));
        end
        foreach (path[i])
            send_char(path[i], produced);
    endtask

    initial
    begin : stimulus
        int produced;
        clear_shadow_name();
        shadow_phase = PhSkip;
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_char(directed_rows[i].ch, produced);
            if (produced != int'(directed_rows[i].results))
            begin
                $display("%0t: row %0d char %h: expected %0d name bytes, predicted %0d",
                         $time, i, directed_rows[i].ch, directed_rows[i].results, produced);
                mismatches++;
            end
        end
        random_chars = 0;
        while (random_chars < RandomChars)
        begin
            if (random_chars >= SqueezeAfter)
                squeeze_req = 1'b1;
            send_random_path();
        end
        in_valid <= 1'b0;
        while (expected_name_bytes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side stalls; one long hold lets the name queue fill up
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                out_stall <= 1'b1;
                repeat (SqueezeCycles) @(posedge clk);
                squeeze_done = 1'b1;
                out_stall <= 1'b0;
            end
            else
            begin
                if (stall_left > 0)
                    stall_left--;
                else if (out_valid && !out_stall)
                    stall_left = pick_gap(rx_calm);
                out_stall <= (stall_left > 0);
            end
        end
    end

    always @(posedge clk)
    begin : check_names
        name_byte_t nb;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_name_bytes.size() == 0)
            begin
                $display("%0t: unexpected item: byte %h index %0d final %b last %b",
                         $time, name_byte, byte_index, final_component, last);
                mismatches++;
            end
            else
            begin
                nb = expected_name_bytes.pop_front();
                if (name_byte !== nb.ch)
                begin
                    $display("%0t: name_byte expected %h got %h", $time, nb.ch, name_byte);
                    mismatches++;
                end
                if (byte_index !== nb.idx)
                begin
                    $display("%0t: byte_index expected %0d got %0d",
                             $time, nb.idx, byte_index);
                    mismatches++;
                end
                if (final_component !== nb.final_comp)
                begin
                    $display("%0t: final_component expected %b got %b",
                             $time, nb.final_comp, final_component);
                    mismatches++;
                end
                if (last !== nb.is_last)
                begin
                    $display("%0t: last expected %b got %b", $time, nb.is_last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
